// ===== rtl/fir_pkg.sv =====
`default_nettype none

package fir_pkg;

    // width of the tap count and coefficient index fields
    localparam int unsigned IDX_W = 6;
    // accumulator guard bits for up to 63 summed products
    localparam int unsigned TAP_GUARD = 6;

    typedef enum logic {
        ACT_FILTER = 1'b0,
        ACT_LOAD   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_FIN
    } t_state;

    // control from the sequencer into the mac unit
    typedef struct packed {
        logic clr;
        logic dv;
    } t_mac_ctl;

    // status back from the mac unit
    typedef struct packed {
        logic busy;
    } t_mac_sts;

endpackage

`default_nettype wire

// ===== rtl/fir_smp_if.sv =====
`default_nettype none

interface fir_smp_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 18
);
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic signed [SAMPLE_WIDTH-1:0]  sample_in;
    logic [fir_pkg::IDX_W-1:0]       coeff_index;
    logic signed [COEFF_WIDTH-1:0]   coeff_value;

    modport source (output valid, action, sample_in, coeff_index, coeff_value, input ready);
    modport sink   (input valid, action, sample_in, coeff_index, coeff_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/fir_res_if.sv =====
`default_nettype none

interface fir_res_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_WIDTH-1:0]  sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/fir_cfg_if.sv =====
`default_nettype none

interface fir_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [fir_pkg::IDX_W-1:0]  tap_count;

    modport source (output valid, tap_count, input ready);
    modport sink   (input valid, tap_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fir_vram.sv =====
`default_nettype none

// synchronous memory, one write and one read port, registered read;
// per-entry valid bits make unwritten entries read as zero
module fir_vram #(
    parameter int DEPTH = 63,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clr,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== rtl/fir_mac.sv =====
`default_nettype none

// shared multiply-accumulate with round and saturate on the running sum
module fir_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 18
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire fir_pkg::t_mac_ctl              i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_smp,
    input  wire logic signed [COEFF_WIDTH-1:0]  i_coef,
    output fir_pkg::t_mac_sts                   o_sts,
    output logic signed [SAMPLE_WIDTH-1:0]      o_result
);

    localparam int ACC_W  = SAMPLE_WIDTH + COEFF_WIDTH + int'(fir_pkg::TAP_GUARD);
    localparam int PROD_W = SAMPLE_WIDTH + COEFF_WIDTH;
    localparam int FS     = COEFF_WIDTH - 2;
    localparam logic signed [ACC_W:0] HALF   = (ACC_W + 1)'(1) << (FS - 1);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W + 1)'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W:0]    w_shf;

    always_ff @(posedge i_clk) begin
        if (i_ctl.dv) begin
            r_prod <= i_smp * i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_prod_v <= i_ctl.dv;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_prod_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // round half up, then clamp to the sample range
    assign w_rnd = (ACC_W + 1)'(r_acc) + HALF;
    assign w_shf = w_rnd >>> FS;

    always_comb begin
        if (w_shf > SAT_HI) begin
            o_result = SAMPLE_WIDTH'(SAT_HI);
        end else if (w_shf < SAT_LO) begin
            o_result = SAMPLE_WIDTH'(SAT_LO);
        end else begin
            o_result = w_shf[SAMPLE_WIDTH-1:0];
        end
    end

    assign o_sts.busy = r_prod_v;

endmodule

`default_nettype wire

// ===== rtl/fir_filter_circular_history.sv =====
// direct-form fir filter over a circular sample history
// i_smp carries one beat per item: action 0 filters sample_in, action 1 loads
// coeff_value at coeff_index (indices of MAX_TAPS or more are dropped, no result)
// o_res carries one filtered sample_out beat per filter item, in order
// i_cfg writes tap_count; it clears the history and the write position, and
// counts above MAX_TAPS act as MAX_TAPS; tap_count 0 passes samples through
// a filter item runs in these steps after its accept beat: the sample is
// stored at the accept edge, then one history read and one coefficient read
// per tap (S_RUN) feed a single shared multiplier; the read, the multiply
// and the last add drain in S_WAIT (the rounded sum is captured once they
// are through), and S_FIN moves it into the output register, waiting while
// the receiver still holds an earlier result
// the next item is taken once the result sits in the output register, so a
// filter or bypassed sample is not taken while the previous one is in flight;
// coefficient loads are taken one per cycle while the filter is idle
// a result held by a stalled receiver blocks only the following result, not
// the accept of the next item
// reset clears tap_count, history and coefficients (per-entry valid bits,
// no clearing pass) and drops any pending result

`default_nettype none

module fir_filter_circular_history #(
    parameter int MAX_TAPS     = 63,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 18
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fir_smp_if.sink    i_smp,
    fir_cfg_if.sink    i_cfg,
    fir_res_if.source  o_res
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int IW = int'(fir_pkg::IDX_W);
    // taps actually usable: the count field tops out at 63
    localparam logic [IW-1:0] TAP_LIM = IW'((MAX_TAPS > 63) ? 63 : MAX_TAPS);

    fir_pkg::t_state r_state;
    fir_pkg::t_state n_state;

    logic [IW-1:0] r_taps;
    logic [IW-1:0] r_wp;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_cnt;
    logic          r_rd_v;
    logic          r_out_v;
    logic signed [SAMPLE_WIDTH-1:0] r_res;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic          w_in_rdy;
    logic          w_rd_en;
    logic          w_fin_go;
    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_is_load;
    logic          w_start;
    logic          w_bypass;
    logic          w_cload;
    logic          w_last;
    logic          w_drained;
    logic [IW-1:0] w_wp_eff;
    logic [IW-1:0] w_wp_inc;
    logic [IW-1:0] w_cfg_taps;

    logic [SAMPLE_WIDTH-1:0]        w_hist_rd;
    logic [COEFF_WIDTH-1:0]         w_coef_rd;
    logic signed [SAMPLE_WIDTH-1:0] w_mac_res;
    fir_pkg::t_mac_ctl              w_mac_ctl;
    fir_pkg::t_mac_sts              w_mac_sts;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_smp.ready = w_in_rdy;
    assign w_in_acc    = i_smp.valid && w_in_rdy;

    // item decode
    assign w_is_load = (i_smp.action == fir_pkg::ACT_LOAD);
    assign w_start   = w_in_acc && !w_is_load && (r_taps != '0);
    assign w_bypass  = w_in_acc && !w_is_load && (r_taps == '0);
    assign w_cload   = w_in_acc && w_is_load && (int'(i_smp.coeff_index) < MAX_TAPS);

    // a stale write position restarts at zero
    assign w_wp_eff = (r_wp >= r_taps) ? '0 : r_wp;
    assign w_wp_inc = ((w_wp_eff + IW'(1)) == r_taps) ? '0 : (w_wp_eff + IW'(1));

    assign w_cfg_taps = (i_cfg.tap_count > TAP_LIM) ? TAP_LIM : i_cfg.tap_count;
    assign w_last     = (r_cnt == (r_taps - IW'(1)));
    assign w_drained  = !r_rd_v && !w_mac_sts.busy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_pkg::S_IDLE: begin
                if (w_start) begin
                    n_state = fir_pkg::S_RUN;
                end else if (w_bypass) begin
                    n_state = fir_pkg::S_FIN;
                end
            end
            fir_pkg::S_RUN: begin
                if (w_last) begin
                    n_state = fir_pkg::S_WAIT;
                end
            end
            fir_pkg::S_WAIT: begin
                if (w_drained) begin
                    n_state = fir_pkg::S_FIN;
                end
            end
            fir_pkg::S_FIN: begin
                if (w_fin_go) begin
                    n_state = fir_pkg::S_IDLE;
                end
            end
            default: n_state = fir_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_in_rdy = 1'b0;
        w_rd_en  = 1'b0;
        w_fin_go = 1'b0;
        unique case (r_state)
            fir_pkg::S_IDLE: w_in_rdy = 1'b1;
            fir_pkg::S_RUN:  w_rd_en  = 1'b1;
            fir_pkg::S_WAIT: ;
            fir_pkg::S_FIN:  w_fin_go = !r_out_v || o_res.ready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fir_pkg::S_IDLE;
            r_taps  <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_rd_en;
            if (w_cfg_acc) begin
                r_taps <= w_cfg_taps;
                r_wp   <= '0;
            end else if (w_start) begin
                r_wp <= w_wp_inc;
            end
            if (w_start) begin
                r_cnt <= '0;
            end else if (w_rd_en) begin
                r_cnt <= r_cnt + IW'(1);
            end
            if (w_fin_go) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pos <= w_wp_eff;
        end else if (w_rd_en) begin
            // walk back through the ring toward older samples
            r_pos <= (r_pos == '0) ? (r_taps - IW'(1)) : (r_pos - IW'(1));
        end
        if (w_bypass) begin
            r_res <= i_smp.sample_in;
        end else if (r_state == fir_pkg::S_WAIT && w_drained) begin
            r_res <= w_mac_res;
        end
        if (w_fin_go) begin
            r_out_data <= r_res;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.sample_out = r_out_data;

    // sample history, cleared by every tap count write
    fir_vram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_WIDTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_cfg_acc),
        .i_we    (w_start),
        .i_waddr (AW'(w_wp_eff)),
        .i_wdata (i_smp.sample_in),
        .i_re    (w_rd_en),
        .i_raddr (AW'(r_pos)),
        .o_rdata (w_hist_rd)
    );

    // coefficients, kept across tap count writes
    fir_vram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEFF_WIDTH),
        .AW    (AW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (1'b0),
        .i_we    (w_cload),
        .i_waddr (AW'(i_smp.coeff_index)),
        .i_wdata (i_smp.coeff_value),
        .i_re    (w_rd_en),
        .i_raddr (AW'(r_cnt)),
        .o_rdata (w_coef_rd)
    );

    assign w_mac_ctl.clr = w_start;
    assign w_mac_ctl.dv  = r_rd_v;

    fir_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_smp    ($signed(w_hist_rd)),
        .i_coef   ($signed(w_coef_rd)),
        .o_sts    (w_mac_sts),
        .o_result (w_mac_res)
    );

    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taps == '0) || (r_wp < r_taps))
        else $error("write position outside the taps in use");

    a_rd_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> ((r_cnt < r_taps) && (r_pos < r_taps)))
        else $error("tap read outside the taps in use");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_pkg::S_FIN) |-> w_drained)
        else $error("result taken before the mac pipeline drained");

    a_last_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fir_pkg::S_RUN && w_last) |=> (r_state == fir_pkg::S_WAIT))
        else $error("tap loop did not stop after the last tap");

endmodule

`default_nettype wire
